[rtl/brs_pkg.sv]
package brs_pkg;

	// fixed field widths
	localparam int SRC_BITS      = 9;
	localparam int DST_BITS      = 13;
	localparam int POS_BITS      = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT = 2'd3;

	// register reset values
	localparam logic [SRC_BITS-1:0] RST_SRC_WIDTH  = 9'd256;
	localparam logic [SRC_BITS-1:0] RST_SRC_HEIGHT = 9'd256;
	localparam logic [DST_BITS-1:0] RST_DST_WIDTH  = 13'd512;
	localparam logic [DST_BITS-1:0] RST_DST_HEIGHT = 13'd512;

	// item modes
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	// parameter defaults
	localparam int DEF_MAX_SRC_WIDTH  = 256;
	localparam int DEF_MAX_SRC_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS     = 16;
	localparam int DEF_FRAC_BITS      = 16;

	// numerator (2k+1)*src before the fraction shift
	localparam int PROD_BITS = POS_BITS + 1 + SRC_BITS;
	// divisor 2*dst
	localparam int DEN_BITS = DST_BITS + 1;

endpackage

[rtl/brs_div.sv]
module brs_div
	import brs_pkg::*;
#(
	parameter int NW = 38,
	parameter int DW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/brs_fstore.sv]
module brs_fstore
	import brs_pkg::*;
#(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int PW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [PW-1:0] wdata,
	output logic [PW-1:0] rdata
);

	logic [PW-1:0] mem [DEPTH];
	logic [PW-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bilinear_image_resampler.sv]
// load transaction: written to the frame store in the accept cycle when col and row are in range, busy stays low
// request transaction: busy until the result is out, shorter when no tap lies in the image;
// the time is set by the bit-serial divider run once per axis plus four tap slots on the
// single-port frame store
// done pulses for one cycle as busy falls; the receiver cannot stall, and the next
// transaction may be accepted in that cycle. arst_n clears control and config, not the store
module bilinear_image_resampler
	import brs_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
	parameter int PIXEL_BITS     = DEF_PIXEL_BITS,
	parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     mode,
	input  logic [POS_BITS-1:0]      col,
	input  logic [POS_BITS-1:0]      row,
	input  logic [PIXEL_BITS-1:0]    pixel,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output logic [PIXEL_BITS-1:0]    out_value,
	output logic                     zero_weight
);

	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = PROD_BITS + FRAC_BITS;
	localparam int UW    = NW + 1;
	localparam int BW    = UW - FRAC_BITS;
	localparam int WW    = FRAC_BITS + 1;
	localparam int PWW   = 2 * WW;
	localparam int ACC_W = PIXEL_BITS + 2 * FRAC_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NUM   = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_TAP   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam logic [WW-1:0]    ONE_W    = WW'(1) << FRAC_BITS;
	localparam logic [UW-1:0]    HALF_U   = UW'(1) << (FRAC_BITS - 1);
	localparam logic [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (2 * FRAC_BITS - 1);

	logic [2:0]             state_q;
	logic                   axis_q;
	logic [POS_BITS-1:0]    col_q;
	logic [POS_BITS-1:0]    row_q;
	logic                   zero_q;

	logic [SRC_BITS-1:0]    src_width_q;
	logic [SRC_BITS-1:0]    src_height_q;
	logic [DST_BITS-1:0]    dst_width_q;
	logic [DST_BITS-1:0]    dst_height_q;

	logic [SRC_BITS-1:0]    sw_eff;
	logic [SRC_BITS-1:0]    sh_eff;
	logic [DST_BITS-1:0]    dw_eff;
	logic [DST_BITS-1:0]    dh_eff;

	logic [POS_BITS-1:0]    k_sel;
	logic [SRC_BITS-1:0]    src_sel;
	logic [DST_BITS-1:0]    dst_sel;
	logic [PROD_BITS-1:0]   num_prod;

	logic                   div_start;
	logic                   div_done;
	logic [NW-1:0]          div_quot;

	logic [UW-1:0]          u_pos;
	logic [BW-1:0]          base;
	logic [FRAC_BITS-1:0]   frac;
	logic [BW-1:0]          src_ext;
	logic                   v0;
	logic                   v1;

	logic [1:0]             tvx_q;
	logic [1:0]             tvy_q;
	logic [SRC_BITS-1:0]    tix_q [2];
	logic [SRC_BITS-1:0]    tiy_q [2];
	logic [WW-1:0]          twx_q [2];
	logic [WW-1:0]          twy_q [2];

	logic [1:0]             tap_q;
	logic                   tap_hit;
	logic                   vld_s1;
	logic [PWW-1:0]         wgt_s1;
	logic [ACC_W-1:0]       acc_q;

	logic                   accept;
	logic                   load_ok;
	logic                   mem_we;
	logic                   mem_re;
	logic [AW-1:0]          mem_addr;
	logic [PIXEL_BITS-1:0]  mem_rdata;

	logic                   done_q;
	logic [PIXEL_BITS-1:0]  out_value_q;
	logic                   zero_weight_q;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			dst_width_q  <= RST_DST_WIDTH;
			dst_height_q <= RST_DST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_BITS-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_BITS-1:0];
				CFG_DST_WIDTH:  dst_width_q  <= cfg_data[DST_BITS-1:0];
				CFG_DST_HEIGHT: dst_height_q <= cfg_data[DST_BITS-1:0];
				default: ;
			endcase
		end
	end

	// saturated source size, zero source or output size acts as one
	always_comb begin
		if (src_width_q == '0) begin
			sw_eff = SRC_BITS'(1);
		end else if (DST_BITS'(src_width_q) > DST_BITS'(MAX_SRC_WIDTH)) begin
			sw_eff = SRC_BITS'(MAX_SRC_WIDTH);
		end else begin
			sw_eff = src_width_q;
		end
		if (src_height_q == '0) begin
			sh_eff = SRC_BITS'(1);
		end else if (DST_BITS'(src_height_q) > DST_BITS'(MAX_SRC_HEIGHT)) begin
			sh_eff = SRC_BITS'(MAX_SRC_HEIGHT);
		end else begin
			sh_eff = src_height_q;
		end
		dw_eff = (dst_width_q == '0) ? DST_BITS'(1) : dst_width_q;
		dh_eff = (dst_height_q == '0) ? DST_BITS'(1) : dst_height_q;
	end

	// numerator (2k+1)*src, then one divider run per axis
	assign k_sel     = axis_q ? row_q : col_q;
	assign src_sel   = axis_q ? sh_eff : sw_eff;
	assign dst_sel   = axis_q ? dh_eff : dw_eff;
	assign num_prod  = PROD_BITS'({k_sel, 1'b1}) * PROD_BITS'(src_sel);
	assign div_start = state_q == S_NUM;

	brs_div #(
		.NW(NW),
		.DW(DEN_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({num_prod, {FRAC_BITS{1'b0}}}),
		.divisor ({dst_sel, 1'b0}),
		.done    (div_done),
		.quotient(div_quot)
	);

	// taps of one axis from t = s + 0.5
	always_comb begin
		u_pos   = {1'b0, div_quot} + HALF_U;
		base    = u_pos[UW-1:FRAC_BITS];
		frac    = u_pos[FRAC_BITS-1:0];
		src_ext = BW'(src_sel);
		v0      = (base != '0) && ((base - 1'b1) < src_ext);
		v1      = (base < src_ext) && (frac != '0);
	end

	assign tap_hit = tvx_q[tap_q[0]] && tvy_q[tap_q[1]];

	// frame store port: loads in the accept cycle, tap reads in the tap slots
	assign load_ok = (DST_BITS'(col) < DST_BITS'(MAX_SRC_WIDTH))
		&& (DST_BITS'(row) < DST_BITS'(MAX_SRC_HEIGHT));
	assign mem_we  = accept && (mode == MODE_LOAD) && load_ok;
	assign mem_re  = (state_q == S_TAP) && tap_hit;

	always_comb begin
		if (busy) begin
			mem_addr = AW'(tiy_q[tap_q[1]]) * AW'(MAX_SRC_WIDTH) + AW'(tix_q[tap_q[0]]);
		end else begin
			mem_addr = AW'(row) * AW'(MAX_SRC_WIDTH) + AW'(col);
		end
	end

	brs_fstore #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.PW   (PIXEL_BITS)
	) u_fstore (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(pixel),
		.rdata(mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			axis_q        <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			zero_q        <= 1'b0;
			tap_q         <= '0;
			vld_s1        <= 1'b0;
			tvx_q         <= '0;
			tvy_q         <= '0;
			done_q        <= 1'b0;
			zero_weight_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= mem_re;
			case (state_q)
				S_IDLE: begin
					if (accept && (mode == MODE_REQUEST)) begin
						axis_q  <= 1'b0;
						col_q   <= col;
						row_q   <= row;
						zero_q  <= 1'b0;
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (!axis_q) begin
							tvx_q <= {v1, v0};
							if (!(v0 || v1)) begin
								zero_q  <= 1'b1;
								state_q <= S_OUT;
							end else begin
								axis_q  <= 1'b1;
								state_q <= S_NUM;
							end
						end else begin
							tvy_q <= {v1, v0};
							tap_q <= '0;
							if (!(v0 || v1)) begin
								zero_q  <= 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_TAP;
							end
						end
					end
				end
				S_TAP: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == 2'd3) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q        <= 1'b1;
					zero_weight_q <= zero_q;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// tap indices and weights, weights of the valid taps of one axis sum to one
	always_ff @(posedge clk) begin
		if ((state_q == S_DIV) && div_done) begin
			if (!axis_q) begin
				tix_q[0] <= SRC_BITS'(base - 1'b1);
				tix_q[1] <= SRC_BITS'(base);
				twx_q[0] <= v1 ? ONE_W - WW'(frac) : ONE_W;
				twx_q[1] <= v0 ? WW'(frac) : ONE_W;
			end else begin
				tiy_q[0] <= SRC_BITS'(base - 1'b1);
				tiy_q[1] <= SRC_BITS'(base);
				twy_q[0] <= v1 ? ONE_W - WW'(frac) : ONE_W;
				twy_q[1] <= v0 ? WW'(frac) : ONE_W;
			end
		end
	end

	// weight product lines up with the registered pixel read
	always_ff @(posedge clk) begin
		wgt_s1 <= PWW'(twx_q[tap_q[0]]) * PWW'(twy_q[tap_q[1]]);
		if ((state_q == S_DIV) && div_done && axis_q) begin
			acc_q <= HALF_ACC;
		end else if (vld_s1) begin
			acc_q <= acc_q + ACC_W'(wgt_s1) * ACC_W'(mem_rdata);
		end
		if (state_q == S_OUT) begin
			out_value_q <= zero_q ? '0 : acc_q[2*FRAC_BITS +: PIXEL_BITS];
		end
	end

	assign done        = done_q;
	assign out_value   = out_value_q;
	assign zero_weight = zero_weight_q;

`ifndef SYNTHESIS
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_OUT)
		else $error("result strobe without a finished request");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_weight) |-> (out_value == '0))
		else $error("zero weight result with nonzero value");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");
`endif

endmodule
